>>> rtl/acoustic_wave_stencil_8th_order_macros.svh
// assertion macros for the stencil rtl
// no dependencies; included by the top level module, which checks its own logic
`ifndef ACOUSTIC_WAVE_STENCIL_8TH_ORDER_MACROS_SVH
`define ACOUSTIC_WAVE_STENCIL_8TH_ORDER_MACROS_SVH

// property must hold at every clock edge outside reset
`define AWS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen outside reset
`define AWS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/aws_pkg.sv
// types, constants and tap tables for the 8th order acoustic wave stencil
// no dependencies; used by every module of the block except aws_ram
package aws_pkg;

  localparam int SAMPLE_BITS  = 32;
  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 18;
  localparam int GRID_W = 11;
  localparam int CRS_W  = 18;
  localparam int SRC_W  = 10;
  localparam int MIN_GRID = 9;

  localparam logic [CFG_AW-1:0] REG_GRID_ROWS = 3'd0;
  localparam logic [CFG_AW-1:0] REG_GRID_COLS = 3'd1;
  localparam logic [CFG_AW-1:0] REG_CRS_ROW   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CRS_COL   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SRC_ROW   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SRC_COL   = 3'd5;

  localparam logic [GRID_W-1:0] GRID_RST = 11'd1024;
  localparam logic [CRS_W-1:0]  CRS_RST  = 18'd32768;

  // arithmetic widths
  localparam int COEF_W  = 21;
  localparam int MAC_W   = SAMPLE_BITS + COEF_W;
  localparam int LAP_W   = SAMPLE_BITS + 26;
  localparam int LAP_SH  = 10;
  localparam int LAPR_W  = LAP_W - LAP_SH;
  localparam int PROD_W  = LAPR_W + CRS_W + 1;
  localparam int BASE_W  = SAMPLE_BITS + 2;
  localparam int OUT_SH  = 25;
  localparam int TOT_W   = PROD_W + 1;
  localparam int Q_W     = TOT_W - OUT_SH;

  localparam logic signed [Q_W-1:0] SAT_HI =
    {{(Q_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [Q_W-1:0] SAT_LO = ~SAT_HI;

  // tap sequencer
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] PREV_STEP  = 5'd1;
  localparam logic [STEP_W-1:0] LAST_TAP   = 5'd16;
  localparam logic [STEP_W-1:0] DRAIN_STEP = 5'd18;

  typedef struct packed {
    logic                          frame_start;
    logic signed [SAMPLE_BITS-1:0] current_value;
    logic signed [SAMPLE_BITS-1:0] previous_value;
    logic signed [SAMPLE_BITS-1:0] source_amount;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] next_value;
    logic signed [SAMPLE_BITS-1:0] center_current;
    logic                          frame_last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_SCALE, ST_MULT, ST_SUM, ST_WRITE, ST_OUT
  } state_t;

  // one stencil tap: where to read and where the product goes
  typedef struct packed {
    logic       valid;
    logic [2:0] coef_idx;
    logic       to_row;
    logic       to_col;
    logic       use_cur;
    logic       is_center;
    logic [2:0] row_off;
    logic       col_neg;
    logic [2:0] col_k;
  } tap_t;

  function automatic logic signed [COEF_W-1:0] tap_coef(input logic [2:0] idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      3'd0:    c = -21'sd746382;
      3'd1:    c = 21'sd419430;
      3'd2:    c = -21'sd52429;
      3'd3:    c = 21'sd6658;
      3'd4:    c = -21'sd468;
      default: c = '0;
    endcase
    return c;
  endfunction

  // center, four up, three down, current sample as fourth down, four left, four right
  function automatic tap_t step_tap(input logic [STEP_W-1:0] j);
    tap_t t;
    t = '0;
    if (j == 5'd0) begin
      t.valid = 1'b1;
      t.to_row = 1'b1;
      t.to_col = 1'b1;
      t.is_center = 1'b1;
    end else if (j inside {[5'd1:5'd4]}) begin
      t.valid = 1'b1;
      t.coef_idx = j[2:0];
      t.to_row = 1'b1;
      t.row_off = 3'(5'd0 - j);
    end else if (j inside {[5'd5:5'd7]}) begin
      t.valid = 1'b1;
      t.coef_idx = 3'(j - 5'd4);
      t.to_row = 1'b1;
      t.row_off = 3'(j - 5'd4);
    end else if (j == 5'd8) begin
      t.valid = 1'b1;
      t.coef_idx = 3'd4;
      t.to_row = 1'b1;
      t.use_cur = 1'b1;
    end else if (j inside {[5'd9:5'd12]}) begin
      t.valid = 1'b1;
      t.coef_idx = 3'(j - 5'd8);
      t.to_col = 1'b1;
      t.col_neg = 1'b1;
      t.col_k = 3'(j - 5'd8);
    end else if (j inside {[5'd13:5'd16]}) begin
      t.valid = 1'b1;
      t.coef_idx = 3'(j - 5'd12);
      t.to_col = 1'b1;
      t.col_k = 3'(j - 5'd12);
    end
    return t;
  endfunction

endpackage

>>> rtl/aws_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module aws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/aws_lap_acc.sv
// multiply-accumulate for the row and column second differences
// depends on aws_pkg; fed by the line store read port
module aws_lap_acc (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   clear,
  input  aws_pkg::tap_t                          tap,
  input  logic signed [aws_pkg::SAMPLE_BITS-1:0] rd_data,
  input  logic signed [aws_pkg::SAMPLE_BITS-1:0] cur,
  output logic signed [aws_pkg::LAP_W-1:0]       lap_row,
  output logic signed [aws_pkg::LAP_W-1:0]       lap_col,
  output logic signed [aws_pkg::SAMPLE_BITS-1:0] center
);
  import aws_pkg::*;

  tap_t tap_d1_r, tap_d2_r;
  logic signed [SAMPLE_BITS-1:0] operand;
  logic signed [MAC_W-1:0]       prod_r;
  logic signed [LAP_W-1:0]       lap_row_r, lap_col_r;
  logic signed [SAMPLE_BITS-1:0] center_r;

  // the fourth tap below the center is the arriving sample itself
  assign operand = tap_d1_r.use_cur ? cur : rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_d1_r <= '0;
      tap_d2_r <= '0;
    end else begin
      tap_d1_r <= tap;
      tap_d2_r <= tap_d1_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= MAC_W'(operand) * MAC_W'(tap_coef(tap_d1_r.coef_idx));
    if (tap_d1_r.valid && tap_d1_r.is_center) begin
      center_r <= rd_data;
    end
    if (clear) begin
      lap_row_r <= '0;
      lap_col_r <= '0;
    end else if (tap_d2_r.valid) begin
      if (tap_d2_r.to_row) begin
        lap_row_r <= lap_row_r + LAP_W'(prod_r);
      end
      if (tap_d2_r.to_col) begin
        lap_col_r <= lap_col_r + LAP_W'(prod_r);
      end
    end
  end

  assign lap_row = lap_row_r;
  assign lap_col = lap_col_r;
  assign center  = center_r;

endmodule

>>> rtl/acoustic_wave_stencil_8th_order.sv
// top level of the streaming 8th order 2d acoustic wave stencil
// depends on aws_pkg, aws_ram, aws_lap_acc and the assertion macro header
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | aws_pkg::in_t, one grid point
//  out_    | output    | out_valid/out_stall | aws_pkg::out_t, one interior update
//  cfg_    | input     | cfg_we              | cfg_addr index, cfg_wdata value
//
// a border point is accepted and then written to the stores; an interior point is
// accepted, issues its line store reads through the single read port, drains
// the multiply-accumulate, goes through scaling and sum, writes the stores
// and loads the result register
// reset is synchronous on rst_n low; the stores need no clearing pass
// a held result stalls the block only when a second result is ready for it
`include "acoustic_wave_stencil_8th_order_macros.svh"

module acoustic_wave_stencil_8th_order #(
  parameter int MAX_COLS = aws_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = aws_pkg::MAX_ROWS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  aws_pkg::in_t               in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output aws_pkg::out_t              out_data,
  input  logic                       cfg_we,
  input  logic [aws_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [aws_pkg::CFG_DW-1:0] cfg_wdata
);
  import aws_pkg::*;

  localparam int CB     = $clog2(MAX_COLS);
  localparam int RB     = $clog2(MAX_ROWS);
  localparam int CSW    = $clog2(MAX_COLS + 1);
  localparam int RSW    = $clog2(MAX_ROWS + 1);
  localparam int LDEPTH = 8 * (1 << CB);
  localparam int DDEPTH = 4 * (1 << CB);

  // configuration registers
  logic [GRID_W-1:0] grid_rows_r, grid_cols_r;
  logic [CRS_W-1:0]  crs_row_r, crs_col_r;
  logic [SRC_W-1:0]  src_row_r, src_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= GRID_RST;
      grid_cols_r <= GRID_RST;
      crs_row_r   <= CRS_RST;
      crs_col_r   <= CRS_RST;
      src_row_r   <= '0;
      src_col_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_ROWS: grid_rows_r <= cfg_wdata[GRID_W-1:0];
        REG_GRID_COLS: grid_cols_r <= cfg_wdata[GRID_W-1:0];
        REG_CRS_ROW:   crs_row_r   <= cfg_wdata[CRS_W-1:0];
        REG_CRS_COL:   crs_col_r   <= cfg_wdata[CRS_W-1:0];
        REG_SRC_ROW:   src_row_r   <= cfg_wdata[SRC_W-1:0];
        REG_SRC_COL:   src_col_r   <= cfg_wdata[SRC_W-1:0];
        default: ;
      endcase
    end
  end

  // grid size clamped to [9, max]
  logic [RSW-1:0] rows_eff;
  logic [CSW-1:0] cols_eff;

  always_comb begin
    if (32'(grid_rows_r) < 32'(MIN_GRID)) begin
      rows_eff = RSW'(MIN_GRID);
    end else if (32'(grid_rows_r) > 32'(MAX_ROWS)) begin
      rows_eff = RSW'(MAX_ROWS);
    end else begin
      rows_eff = RSW'(grid_rows_r);
    end
    if (32'(grid_cols_r) < 32'(MIN_GRID)) begin
      cols_eff = CSW'(MIN_GRID);
    end else if (32'(grid_cols_r) > 32'(MAX_COLS)) begin
      cols_eff = CSW'(MAX_COLS);
    end else begin
      cols_eff = CSW'(grid_cols_r);
    end
  end

  // control state
  state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [RB-1:0] row_cnt_r, row_cnt_nxt;
  logic [CB-1:0] col_cnt_r, col_cnt_nxt;
  logic out_valid_r;

  // per-transaction registers
  logic [RB-1:0] row_r;
  logic [CB-1:0] col_r;
  logic signed [SAMPLE_BITS-1:0] cur_r, prev_r, prev_center_r;
  logic interior_r, last_r;

  logic in_acc, out_load, mem_we, acc_clear;

  // position of the arriving point; frame_start restarts both counters
  logic [RB-1:0] r_now;
  logic [CB-1:0] c_now;
  logic [31:0] r32, c32, rows32, cols32;
  logic interior_now, last_now, src_hit;
  logic signed [SAMPLE_BITS:0] inj_sum;
  logic signed [SAMPLE_BITS-1:0] cur_now;

  assign in_acc = in_valid && !in_stall;
  assign r_now  = in_data.frame_start ? '0 : row_cnt_r;
  assign c_now  = in_data.frame_start ? '0 : col_cnt_r;
  assign r32    = 32'(r_now);
  assign c32    = 32'(c_now);
  assign rows32 = 32'(rows_eff);
  assign cols32 = 32'(cols_eff);

  // the update for the point four rows above is due once this point lands
  assign interior_now = (r32 >= 32'd8) && (r32 < rows32) && (c32 >= 32'd4) &&
                        (c32 + 32'd4 < cols32);
  assign last_now = (r32 == rows32 - 32'd1) && (c32 == cols32 - 32'd5);
  assign src_hit  = (r32 == 32'(src_row_r)) && (c32 == 32'(src_col_r));

  // source injection with saturation
  assign inj_sum = (SAMPLE_BITS+1)'(in_data.current_value) +
                   (SAMPLE_BITS+1)'(in_data.source_amount);

  always_comb begin
    cur_now = in_data.current_value;
    if (src_hit) begin
      if (inj_sum[SAMPLE_BITS] != inj_sum[SAMPLE_BITS-1]) begin
        cur_now = inj_sum[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                       : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end else begin
        cur_now = inj_sum[SAMPLE_BITS-1:0];
      end
    end
  end

  // raster counters
  always_comb begin
    if (c32 + 32'd1 >= cols32) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (r32 + 32'd1 >= rows32) ? '0 : RB'(r_now + RB'(1));
    end else begin
      col_cnt_nxt = CB'(c_now + CB'(1));
      row_cnt_nxt = r_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
      interior_r <= 1'b0;
    end else if (in_acc) begin
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
      interior_r <= interior_now;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_r  <= r_now;
      col_r  <= c_now;
      cur_r  <= cur_now;
      prev_r <= in_data.previous_value;
      last_r <= last_now;
    end
  end

  // tap issue: one line store read per step
  tap_t tap;
  logic [2:0] rd_row;
  logic [CB-1:0] rd_col;
  logic [CB+2:0] line_raddr, line_waddr;
  logic [CB+1:0] dly_addr;
  logic signed [SAMPLE_BITS-1:0] line_rdata, dly_rdata;

  assign tap = (state_r == ST_READ && step_r <= LAST_TAP) ? step_tap(step_r) : '0;

  // row r-4 is the center; rows wrap modulo eight in the line store
  assign rd_row = row_r[2:0] - 3'd4 + tap.row_off;
  assign rd_col = tap.col_neg ? CB'(col_r - CB'(tap.col_k)) : CB'(col_r + CB'(tap.col_k));
  assign line_raddr = {rd_row, rd_col};
  assign line_waddr = {row_r[2:0], col_r};
  assign dly_addr   = {row_r[1:0], col_r};

  // writes come after all reads of the transaction, so the far top tap
  // still sees the sample from eight rows back
  aws_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(LDEPTH)) u_line_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (line_waddr),
    .wdata (cur_r),
    .raddr (line_raddr),
    .rdata (line_rdata)
  );

  aws_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DDEPTH)) u_dly_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (dly_addr),
    .wdata (prev_r),
    .raddr (dly_addr),
    .rdata (dly_rdata)
  );

  always_ff @(posedge clk) begin
    if (state_r == ST_READ && step_r == PREV_STEP) begin
      prev_center_r <= dly_rdata;
    end
  end

  // second differences
  logic signed [LAP_W-1:0] lap_row, lap_col;
  logic signed [SAMPLE_BITS-1:0] center;

  aws_lap_acc u_lap_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (acc_clear),
    .tap     (tap),
    .rd_data (line_rdata),
    .cur     (cur_r),
    .lap_row (lap_row),
    .lap_col (lap_col),
    .center  (center)
  );

  // round Q18 to Q8, scale by the courant factors, add 2*cur - prev in Q25, round and saturate
  logic signed [LAP_W-1:0]  lap_row_b, lap_col_b;
  logic signed [LAPR_W-1:0] lap_row_q_r, lap_col_q_r;
  logic signed [PROD_W-1:0] prod_row_r, prod_col_r;
  logic signed [BASE_W-1:0] base;
  logic signed [TOT_W-1:0]  total_r, total_b;
  logic signed [Q_W-1:0]    q;
  logic signed [SAMPLE_BITS-1:0] next_sat;

  assign lap_row_b = lap_row + LAP_W'(1 << (LAP_SH - 1));
  assign lap_col_b = lap_col + LAP_W'(1 << (LAP_SH - 1));
  assign base = BASE_W'(center) + BASE_W'(center) - BASE_W'(prev_center_r);
  assign total_b = total_r + TOT_W'(1 << (OUT_SH - 1));
  assign q = total_b[TOT_W-1:OUT_SH];

  always_comb begin
    if (q > SAT_HI) begin
      next_sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (q < SAT_LO) begin
      next_sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      next_sat = q[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SCALE) begin
      lap_row_q_r <= lap_row_b[LAP_W-1:LAP_SH];
      lap_col_q_r <= lap_col_b[LAP_W-1:LAP_SH];
    end
    if (state_r == ST_MULT) begin
      prod_row_r <= PROD_W'(lap_row_q_r) * PROD_W'(signed'({1'b0, crs_row_r}));
      prod_col_r <= PROD_W'(lap_col_q_r) * PROD_W'(signed'({1'b0, crs_col_r}));
    end
    if (state_r == ST_SUM) begin
      total_r <= (TOT_W'(base) <<< OUT_SH) + TOT_W'(prod_row_r) + TOT_W'(prod_col_r);
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (state_r == ST_READ) begin
      step_r <= STEP_W'(step_r + STEP_W'(1));
    end else begin
      step_r <= '0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = interior_now ? ST_READ : ST_WRITE;
        end
      end
      ST_READ: begin
        if (step_r == DRAIN_STEP) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: state_nxt = ST_MULT;
      ST_MULT:  state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = interior_r ? ST_OUT : ST_IDLE;
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    acc_clear = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        acc_clear = in_valid;
      end
      ST_WRITE: mem_we = 1'b1;
      ST_OUT:   out_load = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // result register
  out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.next_value     <= next_sat;
      out_data_r.center_current <= center;
      out_data_r.frame_last     <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `AWS_ASSERT(a_out_from_out_state, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_OUT), "result loaded outside output state")
  `AWS_ASSERT(a_border_to_write, clk, rst_n, (in_acc && !interior_now) |=> (state_r == ST_WRITE), "border point did not go to store write")
  `AWS_ASSERT(a_step_bound, clk, rst_n, (state_r == ST_READ) |-> (step_r <= DRAIN_STEP), "tap step ran past drain")
  `AWS_ASSERT_NEVER(a_no_write_in_read, clk, rst_n, mem_we && (step_r != 5'd0), "store written while taps in flight")

endmodule
